/* rtl/lae_pkg.sv */
// ----------------------------------------------------------------------------
// lae_pkg
// Shared types and codes of the lease arbiter: opcodes, requester codes,
// and the item and result records that travel between the stages.
// ----------------------------------------------------------------------------
package lae_pkg;

	localparam int unsigned WordW = 32;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [2:0] {
		OP_ACQUIRE   = 3'd0,
		OP_CHECK     = 3'd1,
		OP_RELEASE   = 3'd2,
		OP_RESERVE   = 3'd3,
		OP_CLR_RSV   = 3'd4,
		OP_CRITICAL  = 3'd5,
		OP_INVALID   = 3'd6,
		OP_STATUS    = 3'd7
	} opcode_t;

	typedef logic [1:0] owner_t;

	localparam owner_t OWN_NONE   = 2'd0;
	localparam owner_t OWN_FAV    = 2'd1;
	localparam owner_t OWN_LOW    = 2'd2;
	// Requester code with no meaning; treated as none everywhere
	localparam owner_t OWN_UNUSED = 2'd3;

	typedef struct packed {
		opcode_t opcode;
		owner_t  requester;
		word_t   lease_number;
		word_t   lease_epoch;
		logic    critical_flag;
	} item_t;

	typedef struct packed {
		logic   ok;
		word_t  granted_number;
		word_t  granted_epoch;
		owner_t holder;
		word_t  epoch_now;
		word_t  critical_entries;
		word_t  reservations_made;
		word_t  preemptions_seen;
		word_t  denials_seen;
		logic   critical_now;
		logic   reserved_now;
	} result_t;

	// Increment that wraps from the top value to 1, never landing on 0.
	function automatic word_t inc_skip_zero(word_t v);
		word_t n;
		n = v + word_t'(1);
		if (n == '0) begin
			n = word_t'(1);
		end
		return n;
	endfunction

endpackage

/* rtl/lae_in_if.sv */
// ----------------------------------------------------------------------------
// lae_in_if
// Event channel into the lease arbiter: valid/ready handshake plus one event.
// ----------------------------------------------------------------------------
interface lae_in_if;
	import lae_pkg::*;

	logic    valid;
	logic    ready;
	opcode_t opcode;
	owner_t  requester;
	word_t   lease_number;
	word_t   lease_epoch;
	logic    critical_flag;

	modport source (
		output valid, opcode, requester, lease_number, lease_epoch, critical_flag,
		input  ready
	);

	modport sink (
		input  valid, opcode, requester, lease_number, lease_epoch, critical_flag,
		output ready
	);

endinterface

/* rtl/lae_out_if.sv */
// ----------------------------------------------------------------------------
// lae_out_if
// Result channel out of the lease arbiter: valid/ready handshake plus one
// result per event.
// ----------------------------------------------------------------------------
interface lae_out_if;
	import lae_pkg::*;

	logic   valid;
	logic   ready;
	logic   ok;
	word_t  granted_number;
	word_t  granted_epoch;
	owner_t holder;
	word_t  epoch_now;
	word_t  critical_entries;
	word_t  reservations_made;
	word_t  preemptions_seen;
	word_t  denials_seen;
	logic   critical_now;
	logic   reserved_now;

	modport source (
		output valid, ok, granted_number, granted_epoch, holder, epoch_now,
		       critical_entries, reservations_made, preemptions_seen, denials_seen,
		       critical_now, reserved_now,
		input  ready
	);

	modport sink (
		input  valid, ok, granted_number, granted_epoch, holder, epoch_now,
		       critical_entries, reservations_made, preemptions_seen, denials_seen,
		       critical_now, reserved_now,
		output ready
	);

endinterface

/* rtl/lae_engine.sv */
// ----------------------------------------------------------------------------
// lae_engine
// Arbiter state and its one-event update. The result of the event presented
// on item is produced combinationally; the state commits when step is high.
// ----------------------------------------------------------------------------
module lae_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  lae_pkg::item_t   item,
	output lae_pkg::result_t result
);
	import lae_pkg::*;

	owner_t holder_q;
	word_t  next_number_q;
	word_t  held_number_q;
	word_t  epoch_q;
	word_t  critical_count_q;
	word_t  reserve_count_q;
	word_t  preempt_count_q;
	word_t  denial_count_q;
	logic   critical_q;
	logic   reserved_q;

	owner_t holder_d;
	word_t  next_number_d;
	word_t  held_number_d;
	word_t  epoch_d;
	word_t  critical_count_d;
	word_t  reserve_count_d;
	word_t  preempt_count_d;
	word_t  denial_count_d;
	logic   critical_d;
	logic   reserved_d;

	owner_t who;
	logic   ok;
	word_t  gnum;
	word_t  gep;
	logic   low_blocked;
	word_t  epoch_inc;
	word_t  number_inc;

	// Unused requester code counts as nobody.
	assign who         = (item.requester == OWN_UNUSED) ? OWN_NONE : item.requester;
	assign low_blocked = critical_q | reserved_q;
	assign epoch_inc   = inc_skip_zero(epoch_q);
	assign number_inc  = inc_skip_zero(next_number_q);

	// Decode the opcode and form the next state
	always_comb begin
		holder_d         = holder_q;
		next_number_d    = next_number_q;
		held_number_d    = held_number_q;
		epoch_d          = epoch_q;
		critical_count_d = critical_count_q;
		reserve_count_d  = reserve_count_q;
		preempt_count_d  = preempt_count_q;
		denial_count_d   = denial_count_q;
		critical_d       = critical_q;
		reserved_d       = reserved_q;
		ok               = 1'b0;
		gnum             = '0;
		gep              = '0;

		unique case (item.opcode)
			OP_ACQUIRE: begin
				if (who != OWN_NONE) begin
					if (holder_q != OWN_NONE || (who == OWN_LOW && low_blocked)) begin
						if (who == OWN_LOW) begin
							denial_count_d = denial_count_q + word_t'(1);
						end
					end else begin
						next_number_d = number_inc;
						held_number_d = number_inc;
						holder_d      = who;
						ok            = 1'b1;
						gnum          = number_inc;
						gep           = epoch_q;
					end
				end
			end
			OP_CHECK: begin
				ok = (who != OWN_NONE) && (who == holder_q) &&
				     (item.lease_number == held_number_q) &&
				     (item.lease_epoch == epoch_q) &&
				     (who != OWN_LOW || !low_blocked);
			end
			OP_RELEASE: begin
				if (who == holder_q && item.lease_number == held_number_q) begin
					holder_d      = OWN_NONE;
					held_number_d = '0;
				end
			end
			OP_RESERVE: begin
				reserved_d = 1'b1;
				if (!reserved_q) begin
					reserve_count_d = reserve_count_q + word_t'(1);
				end
				// Preempt a lower-priority holder
				if (holder_q == OWN_LOW) begin
					epoch_d         = epoch_inc;
					preempt_count_d = preempt_count_q + word_t'(1);
				end
			end
			OP_CLR_RSV: begin
				reserved_d = 1'b0;
			end
			OP_CRITICAL: begin
				if (item.critical_flag && !critical_q) begin
					critical_count_d = critical_count_q + word_t'(1);
					epoch_d          = epoch_inc;
					if (holder_q == OWN_LOW) begin
						preempt_count_d = preempt_count_q + word_t'(1);
					end
				end
				critical_d = item.critical_flag;
			end
			OP_INVALID: begin
				epoch_d       = epoch_inc;
				holder_d      = OWN_NONE;
				held_number_d = '0;
				reserved_d    = 1'b0;
				critical_d    = 1'b0;
			end
			OP_STATUS: begin
			end
			default: begin
			end
		endcase
	end

	// Commit the state on each processed event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holder_q         <= OWN_NONE;
			next_number_q    <= '0;
			held_number_q    <= '0;
			epoch_q          <= word_t'(1);
			critical_count_q <= '0;
			reserve_count_q  <= '0;
			preempt_count_q  <= '0;
			denial_count_q   <= '0;
			critical_q       <= 1'b0;
			reserved_q       <= 1'b0;
		end else if (step) begin
			holder_q         <= holder_d;
			next_number_q    <= next_number_d;
			held_number_q    <= held_number_d;
			epoch_q          <= epoch_d;
			critical_count_q <= critical_count_d;
			reserve_count_q  <= reserve_count_d;
			preempt_count_q  <= preempt_count_d;
			denial_count_q   <= denial_count_d;
			critical_q       <= critical_d;
			reserved_q       <= reserved_d;
		end
	end

	// Report the state as it stands after the event
	always_comb begin
		result.ok                = ok;
		result.granted_number    = gnum;
		result.granted_epoch     = gep;
		result.holder            = holder_d;
		result.epoch_now         = epoch_d;
		result.critical_entries  = critical_count_d;
		result.reservations_made = reserve_count_d;
		result.preemptions_seen  = preempt_count_d;
		result.denials_seen      = denial_count_d;
		result.critical_now      = critical_d;
		result.reserved_now      = reserved_d;
	end

endmodule

/* rtl/lease_arbiter_with_epoch_preemption_core.sv */
// ----------------------------------------------------------------------------
// lease_arbiter_with_epoch_preemption_core
// Lease arbiter for one shared resource between a favored and a
// lower-priority requester, with epoch-stamped leases and preemption.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one event per transfer (opcode, requester, lease number and
//   epoch, critical flag). rsp returns exactly one result per event, in
//   order, with the grant details and the arbiter state after that event.
//   An accepted event lands in the input register; it is evaluated against
//   the arbiter state, and once the output register is free or emptying
//   the state commits and the result is loaded into the output register.
//   rsp valid comes from the output register. Throughput is one event per
//   cycle while rsp does not stall, set by the single evaluation stage
//   between the two registers.
//   When rsp stalls, the output register holds its result and the input
//   register takes one more event, after which req.ready drops until the
//   output register frees up. Events are never dropped or reordered.
//   Reset clears both valid flags and puts the arbiter in its idle state:
//   no holder, epoch 1, all counters zero, not critical, not reserved.
// ----------------------------------------------------------------------------
module lease_arbiter_with_epoch_preemption_core (
	input  logic clk,
	input  logic arst_n,
	lae_in_if.sink    req,
	lae_out_if.source rsp
);
	import lae_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result_c;
	logic    advance;

	// Move the held event forward when the output register is free or emptying
	assign advance   = valid_s1 & (~valid_s2 | rsp.ready);
	assign req.ready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.opcode        <= req.opcode;
			item_s1.requester     <= req.requester;
			item_s1.lease_number  <= req.lease_number;
			item_s1.lease_epoch   <= req.lease_epoch;
			item_s1.critical_flag <= req.critical_flag;
		end
	end

	lae_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result_c)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_c;
		end
	end

	assign rsp.valid             = valid_s2;
	assign rsp.ok                = result_s2.ok;
	assign rsp.granted_number    = result_s2.granted_number;
	assign rsp.granted_epoch     = result_s2.granted_epoch;
	assign rsp.holder            = result_s2.holder;
	assign rsp.epoch_now         = result_s2.epoch_now;
	assign rsp.critical_entries  = result_s2.critical_entries;
	assign rsp.reservations_made = result_s2.reservations_made;
	assign rsp.preemptions_seen  = result_s2.preemptions_seen;
	assign rsp.denials_seen      = result_s2.denials_seen;
	assign rsp.critical_now      = result_s2.critical_now;
	assign rsp.reserved_now      = result_s2.reserved_now;

endmodule
